/* hw/rtl/fsbr_pkg.sv */
package fsbr_pkg;

    // Run pool
    localparam int unsigned POOL_RUNS = 256;
    localparam int unsigned POOL_W    = $clog2(POOL_RUNS + 1);

    // Fixed field widths
    localparam int unsigned SLOT_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned LEN_W   = 16;

    // Block header constants
    localparam logic [15:0] BLOCK_CEIL = 16'h8000;
    localparam logic [3:0]  HDR_BYTES  = 4'd8;

    // Queues
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int unsigned RESQ_DEPTH = 4;
    localparam int unsigned RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int unsigned RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // Stream widths
    localparam int unsigned S_TDATA_W = 144;
    localparam int unsigned M_TDATA_W = 72;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BLOCK = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_e_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_POOL_FULL  = 2'd2
    } status_e_t;

    typedef enum logic {
        KIND_PIECE  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_e_t;

    // Classified command handed from front to back
    typedef struct packed {
        func_e_t     op;
        logic [31:0] file_offset;
        logic [31:0] file_size;
        logic [31:0] folder_data_offset;
        logic [15:0] folder_blocks;
        logic [15:0] block_comp;
        logic [15:0] block_uncomp;
        logic        block_oversized;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        kind_e_t             kind;
        logic [SLOT_W-1:0]   slot;
        logic [31:0]         piece_offset;
        logic [LEN_W-1:0]    piece_length;
        logic [COUNT_W-1:0]  piece_count;
        status_e_t           status;
        logic                last;
    } result_t;

endpackage

/* hw/rtl/fsbr_front.sv */
module fsbr_front import fsbr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output cmd_t                 cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_pop
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;

    cmd_t in_cmd;
    logic keep;
    logic push;
    logic pop;

    always_comb begin
        in_cmd.op                 = func_e_t'(s_tuser);
        in_cmd.file_offset        = s_tdata[31:0];
        in_cmd.file_size          = s_tdata[63:32];
        in_cmd.folder_data_offset = s_tdata[95:64];
        in_cmd.folder_blocks      = s_tdata[111:96];
        in_cmd.block_comp         = s_tdata[127:112];
        in_cmd.block_uncomp       = s_tdata[143:128];
        in_cmd.block_oversized    = (s_tdata[127:112] > BLOCK_CEIL) ||
                                    (s_tdata[143:128] > BLOCK_CEIL);
        case (in_cmd.op)
            FUNC_START, FUNC_BLOCK, FUNC_CLEAR: keep = 1'b1;
            default:                            keep = 1'b0;  // drop unused code
        endcase
    end

    assign s_tready  = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* hw/rtl/fsbr_back.sv */
module fsbr_back import fsbr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          object_size,
    input  cmd_t                 cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    output result_t              res,
    output logic                 res_valid,
    input  logic                 res_pop
);

    // File tracking state
    logic              active_reg, active_next;
    logic [32:0]       block_pos_reg, block_pos_next;
    logic [31:0]       seen_reg, seen_next;
    logic [32:0]       want_reg, want_next;
    logic [31:0]       left_reg, left_next;
    logic [15:0]       blocks_reg, blocks_next;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic [POOL_W-1:0] first_reg, first_next;

    // Result queue
    result_t               rq_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] rq_wr_reg, rq_wr_next;
    logic [RESQ_PTR_W-1:0] rq_rd_reg, rq_rd_next;
    logic [RESQ_CNT_W-1:0] rq_cnt_reg, rq_cnt_next;

    logic    go;
    logic    pop_out;
    logic [1:0] n_res;
    result_t r0, r1;

    // Block arithmetic
    logic [33:0]       blk_end;
    logic              bad;
    logic [33:0]       diff;
    logic              overlap;
    logic [15:0]       from;
    logic [15:0]       take_raw;
    logic [15:0]       take;
    logic [32:0]       piece_pos;
    logic [31:0]       left_after;
    logic [15:0]       blocks_after;
    logic [POOL_W-1:0] pool_after;

    assign cmd_pop   = go;
    assign go        = cmd_valid && (rq_cnt_reg <= RESQ_CNT_W'(RESQ_DEPTH - 2));
    assign res_valid = (rq_cnt_reg != '0);
    assign pop_out   = res_pop && res_valid;
    assign res       = rq_reg[rq_rd_reg];

    always_comb begin
        blk_end  = {1'b0, block_pos_reg} + 34'(HDR_BYTES) + 34'(cmd.block_comp);
        bad      = cmd.block_oversized || (blk_end > 34'(object_size));
        diff     = {1'b0, want_reg} - {2'b00, seen_reg};
        overlap  = diff[33] || (diff[32:0] < 33'(cmd.block_uncomp));
        from     = diff[33] ? 16'd0 : diff[15:0];
        take_raw = cmd.block_uncomp - from;
        take     = (left_reg < 32'(take_raw)) ? left_reg[15:0] : take_raw;
        piece_pos  = block_pos_reg + 33'(HDR_BYTES) + 33'(from);
        left_after = overlap ? left_reg - 32'(take) : left_reg;
        pool_after = overlap ? pool_reg + 1'b1 : pool_reg;
        blocks_after = blocks_reg - 16'd1;
    end

    function automatic result_t make_status(input status_e_t st,
                                            input logic [POOL_W-1:0] first,
                                            input logic [POOL_W-1:0] pool);
        result_t r;
        r.kind         = KIND_STATUS;
        r.slot         = SLOT_W'(first);
        r.piece_offset = '0;
        r.piece_length = '0;
        r.piece_count  = (st == ST_OK) ? COUNT_W'(pool - first) : '0;
        r.status       = st;
        r.last         = 1'b1;
        return r;
    endfunction

    always_comb begin
        active_next    = active_reg;
        block_pos_next = block_pos_reg;
        seen_next      = seen_reg;
        want_next      = want_reg;
        left_next      = left_reg;
        blocks_next    = blocks_reg;
        pool_next      = pool_reg;
        first_next     = first_reg;
        n_res          = 2'd0;
        r0             = make_status(ST_OK, first_reg, pool_reg);
        r1             = r0;

        if (go) begin
            case (cmd.op)
                FUNC_START: begin
                    // Give back the slots of a dropped file
                    if (active_reg) begin
                        pool_next = first_reg;
                    end
                    first_next     = pool_next;
                    active_next    = 1'b1;
                    want_next      = {1'b0, cmd.file_offset};
                    left_next      = cmd.file_size;
                    block_pos_next = {1'b0, cmd.folder_data_offset};
                    blocks_next    = cmd.folder_blocks;
                    seen_next      = '0;
                    if (cmd.file_size == '0) begin
                        r0          = make_status(ST_OK, pool_next, pool_next);
                        n_res       = 2'd1;
                        active_next = 1'b0;
                    end else if (cmd.folder_blocks == '0) begin
                        r0          = make_status(ST_INCOMPLETE, pool_next, pool_next);
                        n_res       = 2'd1;
                        active_next = 1'b0;
                    end
                end
                FUNC_CLEAR: begin
                    pool_next   = '0;
                    first_next  = '0;
                    active_next = 1'b0;
                end
                FUNC_BLOCK: begin
                    if (active_reg) begin
                        if (bad) begin
                            r0          = make_status(ST_INCOMPLETE, first_reg, pool_reg);
                            n_res       = 2'd1;
                            pool_next   = first_reg;
                            active_next = 1'b0;
                        end else if (overlap && (pool_reg >= POOL_W'(POOL_RUNS))) begin
                            r0          = make_status(ST_POOL_FULL, first_reg, pool_reg);
                            n_res       = 2'd1;
                            pool_next   = first_reg;
                            active_next = 1'b0;
                        end else begin
                            seen_next      = seen_reg + 32'(cmd.block_uncomp);
                            block_pos_next = blk_end[32:0];
                            blocks_next    = blocks_after;
                            left_next      = left_after;
                            pool_next      = pool_after;
                            if (overlap) begin
                                want_next       = want_reg + 33'(take);
                                r0.kind         = KIND_PIECE;
                                r0.slot         = SLOT_W'(pool_reg);
                                r0.piece_offset = piece_pos[31:0];
                                r0.piece_length = take;
                                r0.piece_count  = '0;
                                r0.status       = ST_OK;
                                r0.last         = 1'b0;
                            end
                            if (left_after == '0) begin
                                r1          = make_status(ST_OK, first_reg, pool_after);
                                active_next = 1'b0;
                            end else if (blocks_after == '0) begin
                                r1          = make_status(ST_INCOMPLETE, first_reg,
                                                          pool_after);
                                pool_next   = first_reg;
                                active_next = 1'b0;
                            end
                            // Pack the piece and the closing status in order
                            if (overlap && !active_next) begin
                                n_res = 2'd2;
                            end else if (overlap) begin
                                n_res = 2'd1;
                            end else if (!active_next) begin
                                r0    = r1;
                                n_res = 2'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rq_wr_next  = rq_wr_reg + RESQ_PTR_W'(n_res);
        rq_rd_next  = pop_out ? rq_rd_reg + 1'b1 : rq_rd_reg;
        rq_cnt_next = rq_cnt_reg + RESQ_CNT_W'(n_res) - RESQ_CNT_W'(pop_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            block_pos_reg <= '0;
            seen_reg      <= '0;
            want_reg      <= '0;
            left_reg      <= '0;
            blocks_reg    <= '0;
            pool_reg      <= '0;
            first_reg     <= '0;
            rq_wr_reg     <= '0;
            rq_rd_reg     <= '0;
            rq_cnt_reg    <= '0;
        end else begin
            active_reg    <= active_next;
            block_pos_reg <= block_pos_next;
            seen_reg      <= seen_next;
            want_reg      <= want_next;
            left_reg      <= left_next;
            blocks_reg    <= blocks_next;
            pool_reg      <= pool_next;
            first_reg     <= first_next;
            rq_wr_reg     <= rq_wr_next;
            rq_rd_reg     <= rq_rd_next;
            rq_cnt_reg    <= rq_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            rq_reg[rq_wr_reg] <= r0;
        end
        if (n_res == 2'd2) begin
            rq_reg[rq_wr_reg + 1'b1] <= r1;
        end
    end

endmodule

/* hw/rtl/folder_span_to_block_runs_core.sv */
// Maps one stored file of an uncompressed cabinet folder onto the object byte
// ranges that hold it. Send a start transaction (tuser 0) with the file's
// offset and size in the folder's decoded stream and the folder's first block
// header offset and block count, then one transaction per block header
// (tuser 1). For every block the file overlaps the core returns a range piece
// (tuser 0) carrying a run-pool slot; the file ends with one status
// transaction (tuser 1, tlast high) giving the first slot, the piece count and
// ok, incomplete or pool full. Failed files give their slots back; tuser 2
// empties the pool. Rate: one input transaction per clock while the result
// queue has room. A block that yields both a piece and the closing status
// gives two transactions, so the result port, not the input, is the limit
// there. A 4-deep command queue separates input classification from the file
// tracker, and a 4-deep result queue lets m_tready stall without stopping
// s_tready until the command queue fills. Write object_size only while idle.
module folder_span_to_block_runs_core import fsbr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration: object_size
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,

    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata, low bit up: file_offset[31:0], file_size[63:32],
    // folder_data_offset[95:64], folder_blocks[111:96], block_comp[127:112],
    // block_uncomp[143:128]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]           s_tuser,

    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata, low bit up: slot[7:0], piece_offset[39:8], piece_length[55:40],
    // piece_count[64:56], status[66:65], zero pad[71:67]
    output logic [M_TDATA_W-1:0] m_tdata,
    // tuser: kind[0]
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic [31:0] object_size_reg;

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t res;

    // Hold the object size; the user is to write it only between files, which the block itself does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            object_size_reg <= '0;
        end else if (cfg_we) begin
            object_size_reg <= cfg_wdata;
        end
    end

    // Accept and classify transactions, queue them for the tracker
    fsbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Track block position and decoded bytes, hand out pieces and statuses
    fsbr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .object_size (object_size_reg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .res         (res),
        .res_valid   (m_tvalid),
        .res_pop     (m_tready)
    );

    // Pack the result transaction onto the bus
    assign m_tdata = {5'b0, res.status, res.piece_count, res.piece_length,
                      res.piece_offset, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
